@@ rtl/core/dfa_pkg.sv @@
// Constants and codes shared by the dipole field accumulator.
package dfa_pkg;

  localparam int DISP_FRAC_BITS_DEF = 12;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_FIELD_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_SQ   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIST_TOL    = 2'd2;

  localparam logic [23:0] FIELD_SCALE_RESET = 24'd65536;

  localparam logic [46:0] LIM46 = 47'h3FFF_FFFF_FFFF;
  localparam logic [47:0] LIM47 = 48'h7FFF_FFFF_FFFF;

  localparam logic [1:0] OP_MUL  = 2'd0;
  localparam logic [1:0] OP_DIV  = 2'd1;
  localparam logic [1:0] OP_SQRT = 2'd2;

endpackage

@@ rtl/core/dipole_field_accumulator.sv @@
// Dipole field accumulator: sequencer around one shared shift-add/subtract unit.
//
//   channel | direction | handshake             | payload
//   cfg     | in        | cfg_we                | cfg_index, cfg_data
//   in      | in        | in_valid / in_ready   | disp_*, spin_*, moments, is_self, last_neighbour
//   out     | out       | out_valid / out_ready | field_x/y/z, saturated
//
// A kept neighbour's time is set by the shared unit: a shift-add multiply one bit a
// cycle, a restoring divide one quotient bit a cycle (twelve divides per item) and a
// square root two bits a cycle.
// A skipped neighbour still spends time on the squared distance.
// Reset is synchronous; there is no clearing pass.
// A last item whose result cannot yet be loaded waits until the output register frees.
module dipole_field_accumulator #(
  parameter int DISP_FRAC_BITS = dfa_pkg::DISP_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [dfa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dfa_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [23:0]              disp_x,
  input  logic signed [23:0]              disp_y,
  input  logic signed [23:0]              disp_z,
  input  logic signed [15:0]              spin_x,
  input  logic signed [15:0]              spin_y,
  input  logic signed [15:0]              spin_z,
  input  logic [15:0]                     neighbour_moment,
  input  logic [15:0]                     centre_moment,
  input  logic                            is_self,
  input  logic                            last_neighbour,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [31:0]              field_x,
  output logic signed [31:0]              field_y,
  output logic signed [31:0]              field_z,
  output logic                            saturated
);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_RUN      = 5'd1;
  localparam logic [4:0] S_R2_START = 5'd2;
  localparam logic [4:0] S_R2_ACC   = 5'd3;
  localparam logic [4:0] S_CHECK    = 5'd4;
  localparam logic [4:0] S_SQ_DONE  = 5'd5;
  localparam logic [4:0] S_U_START  = 5'd6;
  localparam logic [4:0] S_U_DONE   = 5'd7;
  localparam logic [4:0] S_P_START  = 5'd8;
  localparam logic [4:0] S_P_ACC    = 5'd9;
  localparam logic [4:0] S_W0       = 5'd10;
  localparam logic [4:0] S_W1       = 5'd11;
  localparam logic [4:0] S_W2       = 5'd12;
  localparam logic [4:0] S_G_START  = 5'd13;
  localparam logic [4:0] S_G_DONE   = 5'd14;
  localparam logic [4:0] S_D_START  = 5'd15;
  localparam logic [4:0] S_D_DONE   = 5'd16;
  localparam logic [4:0] S_C_START  = 5'd17;
  localparam logic [4:0] S_C_DONE   = 5'd18;
  localparam logic [4:0] S_FINISH   = 5'd19;

  logic [4:0]  state;
  logic [4:0]  ret;
  logic [1:0]  eop;
  logic [87:0] acc;
  logic [87:0] opa;
  logic [63:0] opb;
  logic [6:0]  cnt;
  logic [1:0]  idx;
  logic [1:0]  pass;

  logic [23:0] field_scale;
  logic [47:0] cutoff_squared;
  logic [23:0] distance_tolerance;

  logic [23:0]        rmag [3];
  logic               rsgn [3];
  logic [15:0]        smag [3];
  logic signed [15:0] sval [3];
  logic [15:0]        nmom;
  logic [15:0]        cmom;
  logic               self_q;
  logic               last_q;

  logic [47:0]        r2;
  logic [23:0]        rl;
  logic [24:0]        umag [3];
  logic               usgn [3];
  logic [43:0]        pacc;
  logic [29:0]        pmag;
  logic               psgn;
  logic [39:0]        w;
  logic [46:0]        gm;
  logic               gs;

  logic signed [47:0] sum [3];

  logic [87:0] mul_sum;
  logic [24:0] div_sh;
  logic        div_ge;
  logic [24:0] div_sub;
  logic [87:0] sq_t;
  logic        sq_ge;
  logic [48:0] limit;
  logic [43:0] p_add;
  logic [43:0] pabs;
  logic [56:0] t3e;
  logic [56:0] t3s;
  logic [56:0] sshift;
  logic [56:0] gval;
  logic [56:0] gabs;
  logic [46:0] qclamp;
  logic [46:0] cmag;
  logic [48:0] cval;
  logic [48:0] ssum;
  logic        out_load;

  function automatic logic [47:0] sat47(input logic [48:0] v);
    logic signed [48:0] sv;
    sv = $signed(v);
    if (sv > $signed({1'b0, dfa_pkg::LIM47})) begin
      return dfa_pkg::LIM47;
    end else if (sv < -$signed({1'b0, dfa_pkg::LIM47})) begin
      return -dfa_pkg::LIM47;
    end
    return v[47:0];
  endfunction

  function automatic logic over32(input logic signed [47:0] v);
    return (v > 48'sh7FFF_FFFF) || (v < -48'sh8000_0000);
  endfunction

  function automatic logic [31:0] clip32(input logic signed [47:0] v);
    if (v > 48'sh7FFF_FFFF) begin
      return 32'h7FFF_FFFF;
    end else if (v < -48'sh8000_0000) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  assign in_ready = (state == S_IDLE);
  assign out_load = (state == S_FINISH) && last_q && (!out_valid || out_ready);

  always_comb begin
    mul_sum = acc + opa;
    div_sh  = {acc[23:0], opa[62]};
    div_ge  = div_sh >= {1'b0, rl};
    div_sub = div_sh - {1'b0, rl};
    sq_t    = 88'(opb) + opa;
    sq_ge   = acc >= sq_t;
    limit   = {1'b0, cutoff_squared} + 49'(distance_tolerance);
    p_add   = (smag[idx] != 16'd0 && (sval[idx][15] ^ usgn[idx])) ?
              -44'(acc[40:0]) : 44'(acc[40:0]);
    pabs    = pacc[43] ? -pacc : pacc;
    t3e     = 57'(acc[51:0]) + 57'({acc[51:0], 1'b0});
    t3s     = (usgn[idx] ^ psgn) ? -t3e : t3e;
    sshift  = {{7{sval[idx][15]}}, sval[idx], 34'b0};
    gval    = t3s - sshift;
    gabs    = gval[56] ? -gval : gval;
    qclamp  = (opb[62:0] > 63'(dfa_pkg::LIM46)) ? dfa_pkg::LIM46 : opb[46:0];
    cmag    = (acc[87:63] != 25'd0) ? dfa_pkg::LIM47[46:0] : 47'(acc[62:24]);
    cval    = gs ? -49'(cmag) : 49'(cmag);
    ssum    = {sum[idx][47], sum[idx]} + cval;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      out_valid          <= 1'b0;
      field_scale        <= dfa_pkg::FIELD_SCALE_RESET;
      cutoff_squared     <= '0;
      distance_tolerance <= '0;
      for (int n = 0; n < 3; n++) begin
        sum[n] <= '0;
      end
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          dfa_pkg::REG_FIELD_SCALE: field_scale        <= cfg_data[23:0];
          dfa_pkg::REG_CUTOFF_SQ:   cutoff_squared     <= cfg_data[47:0];
          dfa_pkg::REG_DIST_TOL:    distance_tolerance <= cfg_data[23:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            rmag[0] <= 24'(disp_x[23] ? -disp_x : disp_x);
            rmag[1] <= 24'(disp_y[23] ? -disp_y : disp_y);
            rmag[2] <= 24'(disp_z[23] ? -disp_z : disp_z);
            rsgn[0] <= disp_x[23];
            rsgn[1] <= disp_y[23];
            rsgn[2] <= disp_z[23];
            smag[0] <= 16'(spin_x[15] ? -spin_x : spin_x);
            smag[1] <= 16'(spin_y[15] ? -spin_y : spin_y);
            smag[2] <= 16'(spin_z[15] ? -spin_z : spin_z);
            sval[0] <= spin_x;
            sval[1] <= spin_y;
            sval[2] <= spin_z;
            nmom    <= neighbour_moment;
            cmom    <= centre_moment;
            self_q  <= is_self;
            last_q  <= last_neighbour;
            r2      <= '0;
            idx     <= 2'd0;
            state   <= S_R2_START;
          end
        end
        S_RUN: begin
          case (eop)
            dfa_pkg::OP_MUL: begin
              if (opb == 64'd0) begin
                state <= ret;
              end else begin
                if (opb[0]) begin
                  acc <= mul_sum;
                end
                opa <= opa << 1;
                opb <= opb >> 1;
              end
            end
            dfa_pkg::OP_DIV: begin
              if (cnt == 7'd0) begin
                state <= ret;
              end else begin
                acc <= 88'(div_ge ? div_sub : div_sh);
                opa <= opa << 1;
                opb <= {opb[62:0], div_ge};
                cnt <= cnt - 7'd1;
              end
            end
            dfa_pkg::OP_SQRT: begin
              if (opa == 88'd0) begin
                state <= ret;
              end else begin
                if (sq_ge) begin
                  acc <= acc - sq_t;
                  opb <= (opb >> 1) + opa[63:0];
                end else begin
                  opb <= opb >> 1;
                end
                opa <= opa >> 2;
              end
            end
            default: state <= ret;
          endcase
        end
        S_R2_START: begin
          eop   <= dfa_pkg::OP_MUL;
          acc   <= '0;
          opa   <= 88'(rmag[idx]);
          opb   <= 64'(rmag[idx]);
          ret   <= S_R2_ACC;
          state <= S_RUN;
        end
        S_R2_ACC: begin
          r2 <= r2 + acc[47:0];
          if (idx == 2'd2) begin
            state <= S_CHECK;
          end else begin
            idx   <= idx + 2'd1;
            state <= S_R2_START;
          end
        end
        S_CHECK: begin
          if (self_q || r2 == 48'd0 || {1'b0, r2} > limit) begin
            state <= S_FINISH;
          end else begin
            eop   <= dfa_pkg::OP_SQRT;
            acc   <= 88'(r2);
            opa   <= 88'd1 << 46;
            opb   <= '0;
            ret   <= S_SQ_DONE;
            state <= S_RUN;
          end
        end
        S_SQ_DONE: begin
          rl    <= opb[23:0];
          idx   <= 2'd0;
          state <= S_U_START;
        end
        S_U_START: begin
          eop   <= dfa_pkg::OP_DIV;
          acc   <= '0;
          opa   <= 88'(rmag[idx]) << 39;
          opb   <= '0;
          cnt   <= 7'd48;
          ret   <= S_U_DONE;
          state <= S_RUN;
        end
        S_U_DONE: begin
          umag[idx] <= opb[24:0];
          usgn[idx] <= rsgn[idx];
          if (idx == 2'd2) begin
            idx   <= 2'd0;
            pacc  <= '0;
            state <= S_P_START;
          end else begin
            idx   <= idx + 2'd1;
            state <= S_U_START;
          end
        end
        S_P_START: begin
          eop   <= dfa_pkg::OP_MUL;
          acc   <= '0;
          opa   <= 88'(smag[idx]);
          opb   <= 64'(umag[idx]);
          ret   <= S_P_ACC;
          state <= S_RUN;
        end
        S_P_ACC: begin
          pacc <= pacc + p_add;
          if (idx == 2'd2) begin
            state <= S_W0;
          end else begin
            idx   <= idx + 2'd1;
            state <= S_P_START;
          end
        end
        S_W0: begin
          psgn  <= pacc[43];
          pmag  <= pabs[43:14];
          eop   <= dfa_pkg::OP_MUL;
          acc   <= '0;
          opa   <= 88'(field_scale);
          opb   <= 64'(cmom);
          ret   <= S_W1;
          state <= S_RUN;
        end
        S_W1: begin
          eop   <= dfa_pkg::OP_MUL;
          acc   <= '0;
          opa   <= 88'(acc[39:0]);
          opb   <= 64'(nmom);
          ret   <= S_W2;
          state <= S_RUN;
        end
        S_W2: begin
          w     <= acc[55:16];
          idx   <= 2'd0;
          state <= S_G_START;
        end
        S_G_START: begin
          eop   <= dfa_pkg::OP_MUL;
          acc   <= '0;
          opa   <= 88'(umag[idx]);
          opb   <= 64'(pmag);
          ret   <= S_G_DONE;
          state <= S_RUN;
        end
        S_G_DONE: begin
          gs    <= gval[56];
          gm    <= 47'(gabs[56:24]);
          pass  <= 2'd0;
          state <= S_D_START;
        end
        S_D_START: begin
          eop   <= dfa_pkg::OP_DIV;
          acc   <= '0;
          opa   <= 88'(gm) << DISP_FRAC_BITS;
          opb   <= '0;
          cnt   <= 7'd63;
          ret   <= S_D_DONE;
          state <= S_RUN;
        end
        S_D_DONE: begin
          gm <= qclamp;
          if (pass == 2'd2) begin
            state <= S_C_START;
          end else begin
            pass  <= pass + 2'd1;
            state <= S_D_START;
          end
        end
        S_C_START: begin
          eop   <= dfa_pkg::OP_MUL;
          acc   <= '0;
          opa   <= 88'(gm);
          opb   <= 64'(w);
          ret   <= S_C_DONE;
          state <= S_RUN;
        end
        S_C_DONE: begin
          sum[idx] <= $signed(sat47(ssum));
          if (idx == 2'd2) begin
            state <= S_FINISH;
          end else begin
            idx   <= idx + 2'd1;
            state <= S_G_START;
          end
        end
        S_FINISH: begin
          if (!last_q) begin
            state <= S_IDLE;
          end else if (out_load) begin
            field_x   <= $signed(clip32(sum[0]));
            field_y   <= $signed(clip32(sum[1]));
            field_z   <= $signed(clip32(sum[2]));
            saturated <= over32(sum[0]) || over32(sum[1]) || over32(sum[2]);
            for (int n = 0; n < 3; n++) begin
              sum[n] <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ tb/sv/tb_dipole_field_accumulator.sv @@
// Self-checking testbench for the dipole field accumulator: directed and random neighbour runs.
`timescale 1ns / 1ps

module tb_dipole_field_accumulator;

  localparam logic [dfa_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int  FRAC = dfa_pkg::DISP_FRAC_BITS_DEF;
  localparam longint CLAMP46 = 64'sh3FFF_FFFF_FFFF;
  localparam longint CLAMP47 = 64'sh7FFF_FFFF_FFFF;
  localparam longint CYCLE_LIMIT = 40_000_000;
  localparam int  SETTLE = 1600;

  typedef struct packed {
    logic signed [23:0] dx, dy, dz;
    logic signed [15:0] sx, sy, sz;
    logic [15:0] nmom, cmom;
    logic self_f, last_f;
  } nbr_t;

  typedef struct packed {
    logic signed [31:0] fx, fy, fz;
    logic sat;
  } field_t;

  logic clk = 0, rst;
  logic cfg_we;
  logic [dfa_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [dfa_pkg::CFG_DATA_W-1:0] cfg_data;
  logic in_valid, in_ready, out_valid, out_ready;
  logic signed [23:0] disp_x, disp_y, disp_z;
  logic signed [15:0] spin_x, spin_y, spin_z;
  logic [15:0] neighbour_moment, centre_moment;
  logic is_self, last_neighbour;
  logic signed [31:0] field_x, field_y, field_z;
  logic saturated;

  dipole_field_accumulator uut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  field_t field_q[$];
  int errors = 0;
  int send_idle_pct = 0, recv_stall_pct = 0;
  logic hold_req = 0, hold_on = 0;
  longint cycles = 0;

  longint unsigned scale_r, cutoff_r, tol_r;
  longint acc_x, acc_y, acc_z;

  function automatic longint shr_trunc(longint v, int k);
    return v < 0 ? -((-v) >>> k) : (v >>> k);
  endfunction

  function automatic longint clip(longint v, longint lim);
    return v > lim ? lim : (v < -lim ? -lim : v);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res = 0, b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint dipole_term(longint u, longint s, longint p, longint rl,
                                         longint unsigned w);
    longint g;
    longint unsigned gm, mag;
    g = shr_trunc(3 * u * p - s * (64'sd1 <<< 34), 24);
    repeat (3) g = clip((g * (64'sd1 <<< FRAC)) / rl, CLAMP46);
    gm = g < 0 ? longint'(-g) : longint'(g);
    if (w != 0 && gm > 64'h7FFF_FFFF_FFFF_FFFF / w) begin
      mag = CLAMP47;
    end else begin
      mag = (gm * w) >> 24;
      if (mag > CLAMP47) mag = CLAMP47;
    end
    return g < 0 ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic logic signed [31:0] sat32(longint v, ref logic sat);
    if (v > 64'sd2147483647) begin
      v = 64'sd2147483647;
      sat = 1;
    end
    if (v < -64'sd2147483648) begin
      v = -64'sd2147483648;
      sat = 1;
    end
    return v[31:0];
  endfunction

  task automatic accumulate_neighbour(nbr_t it);
    longint r[3], s[3], u[3], p, rl, r2;
    longint unsigned w;
    field_t f;
    logic sat;
    r = '{longint'(it.dx), longint'(it.dy), longint'(it.dz)};
    s = '{longint'(it.sx), longint'(it.sy), longint'(it.sz)};
    r2 = r[0] * r[0] + r[1] * r[1] + r[2] * r[2];
    p = 0;
    if (!it.self_f && r2 != 0 && longint'(r2) <= longint'(cutoff_r + tol_r)) begin
      rl = int_sqrt(r2);
      for (int i = 0; i < 3; i++) begin
        u[i] = (r[i] * (64'sd1 <<< 24)) / rl;
        p += s[i] * u[i];
      end
      p = shr_trunc(p, 14);
      w = (scale_r * longint'(it.cmom) * longint'(it.nmom)) >> 16;
      acc_x = clip(acc_x + dipole_term(u[0], s[0], p, rl, w), CLAMP47);
      acc_y = clip(acc_y + dipole_term(u[1], s[1], p, rl, w), CLAMP47);
      acc_z = clip(acc_z + dipole_term(u[2], s[2], p, rl, w), CLAMP47);
    end
    if (it.last_f) begin
      sat = 0;
      f.fx = sat32(acc_x, sat);
      f.fy = sat32(acc_y, sat);
      f.fz = sat32(acc_z, sat);
      f.sat = sat;
      field_q.push_back(f);
      acc_x = 0;
      acc_y = 0;
      acc_z = 0;
    end
  endtask

  task automatic send_neighbour(nbr_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1;
    {disp_x, disp_y, disp_z} <= {it.dx, it.dy, it.dz};
    {spin_x, spin_y, spin_z} <= {it.sx, it.sy, it.sz};
    neighbour_moment <= it.nmom;
    centre_moment <= it.cmom;
    is_self <= it.self_f;
    last_neighbour <= it.last_f;
    do @(posedge clk); while (!in_ready);
    accumulate_neighbour(it);
  endtask

  task automatic wait_idle();
    in_valid <= 0;
    wait (field_q.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [dfa_pkg::CFG_IDX_W-1:0] idx, longint unsigned val);
    wait_idle();
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val[47:0];
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      dfa_pkg::REG_FIELD_SCALE: scale_r = val & 64'hFF_FFFF;
      dfa_pkg::REG_CUTOFF_SQ:   cutoff_r = val & 64'hFFFF_FFFF_FFFF;
      dfa_pkg::REG_DIST_TOL:    tol_r = val & 64'hFF_FFFF;
      default: ;
    endcase
  endtask

  function automatic nbr_t mk(longint dx, longint dy, longint dz, longint sx, longint sy,
                              longint sz, longint nm, longint cm, bit sf, bit lf);
    nbr_t it;
    it.dx = 24'(dx); it.dy = 24'(dy); it.dz = 24'(dz);
    it.sx = 16'(sx); it.sy = 16'(sy); it.sz = 16'(sz);
    it.nmom = 16'(nm); it.cmom = 16'(cm);
    it.self_f = sf; it.last_f = lf;
    return it;
  endfunction

  function automatic logic signed [23:0] rand_disp();
    logic [23:0] raw = 24'($urandom);
    return $signed(raw) >>> $urandom_range(23);
  endfunction

  function automatic logic signed [15:0] rand_spin();
    return 16'($urandom_range(32768)) - 16'sd16384;
  endfunction

  task automatic send_run(int len, ref int sent);
    nbr_t it;
    logic [15:0] cm = 16'($urandom);
    bit noisy = ($urandom_range(99) < 15);
    for (int i = 0; i < len; i++) begin
      it.dx = rand_disp(); it.dy = rand_disp(); it.dz = rand_disp();
      it.sx = rand_spin(); it.sy = rand_spin(); it.sz = rand_spin();
      it.nmom = 16'($urandom);
      it.cmom = cm;
      it.self_f = 0;
      if (noisy) begin
        it.self_f = $urandom_range(3) == 0;
        if ($urandom_range(4) == 0) {it.dx, it.dy, it.dz} = '0;
        if ($urandom_range(3) == 0) it.cmom = 16'($urandom);
      end
      it.last_f = (i == len - 1) || (noisy && $urandom_range(9) == 0);
      send_neighbour(it);
      sent++;
    end
  endtask

  task automatic random_runs(int n_items);
    int sent = 0;
    while (sent < n_items) send_run($urandom_range(1, 8), sent);
  endtask

  task automatic test_directed();
    send_neighbour(mk(4096, 0, 0, 16384, 0, 0, 256, 256, 0, 1));
    write_reg(dfa_pkg::REG_CUTOFF_SQ, 64'hFFFF_FFFF_FFFF);
    write_reg(dfa_pkg::REG_DIST_TOL, 64'hFF_FFFF);
    send_neighbour(mk(8388607, 8388607, 8388607, 16384, 16384, 16384, 65535, 65535, 1, 0));
    send_neighbour(mk(0, 0, 0, 16384, -16384, 0, 65535, 65535, 0, 0));
    send_neighbour(mk(8388607, 8388607, 8388607, 16384, 16384, 16384, 65535, 65535, 0, 0));
    send_neighbour(mk(-8388608, -8388608, -8388608, -16384, -16384, -16384, 65535, 65535,
                      0, 1));
    send_neighbour(mk(4096, 4096, -4096, 0, 0, 16384, 0, 0, 0, 1));
    send_neighbour(mk(4096, 0, 0, 16384, 0, 0, 256, 0, 0, 1));
    write_reg(dfa_pkg::REG_FIELD_SCALE, 64'hFF_FFFF);
    send_neighbour(mk(1, 0, 0, 16384, 0, 0, 65535, 65535, 0, 1));
    send_neighbour(mk(0, -1, 0, 0, -16384, 0, 65535, 65535, 0, 0));
    send_neighbour(mk(1, 1, 1, 16384, 16384, 0, 65535, 65535, 0, 1));
    write_reg(dfa_pkg::REG_FIELD_SCALE, 64'd0);
    send_neighbour(mk(8192, 0, 0, 16384, 0, 0, 65535, 65535, 0, 1));
    write_reg(dfa_pkg::REG_FIELD_SCALE, 64'd65536);
    write_reg(dfa_pkg::REG_CUTOFF_SQ, 64'd1 << 26);
    write_reg(dfa_pkg::REG_DIST_TOL, 64'd0);
    send_neighbour(mk(8192, 0, 0, 16384, 0, 0, 256, 256, 0, 0));
    send_neighbour(mk(8192, 1, 0, 0, 16384, 0, 256, 256, 0, 0));
    send_neighbour(mk(0, 0, -8192, 0, 0, -16384, 256, 256, 0, 1));
    send_neighbour(mk(8192, 0, 1, 0, 16384, 0, 512, 256, 0, 1));
    write_reg(dfa_pkg::REG_DIST_TOL, 64'd1);
    send_neighbour(mk(8192, 0, 1, 0, 16384, 0, 512, 256, 0, 1));
    write_reg(REG_UNUSED, 64'd0);
    send_neighbour(mk(4096, 4096, 0, 16384, 0, 0, 256, 256, 0, 1));
  endtask

  task automatic test_random(int idle, int stall, longint unsigned scale,
                             longint unsigned cut, longint unsigned tol, int n);
    write_reg(dfa_pkg::REG_FIELD_SCALE, scale);
    write_reg(dfa_pkg::REG_CUTOFF_SQ, cut);
    write_reg(dfa_pkg::REG_DIST_TOL, tol);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    random_runs(n);
  endtask

  task automatic test_backpressure();
    wait_idle();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1;
    random_runs(150);
  endtask

  initial begin
    forever begin
      wait (hold_req);
      @(posedge clk);
      hold_on <= 1;
      repeat (30000) @(posedge clk);
      hold_on <= 0;
      hold_req = 0;
    end
  end

  always @(posedge clk) begin
    field_t e;
    if (rst) begin
      out_ready <= 0;
    end else begin
      out_ready <= !hold_on && ($urandom_range(99) >= recv_stall_pct);
      if (out_valid && out_ready) begin
        if (field_q.size() == 0) begin
          $error("unexpected result: field_x %0d", field_x);
          errors++;
        end else begin
          e = field_q.pop_front();
          if (field_x !== e.fx) begin
            $error("field_x expected %0d actual %0d", e.fx, field_x);
            errors++;
          end
          if (field_y !== e.fy) begin
            $error("field_y expected %0d actual %0d", e.fy, field_y);
            errors++;
          end
          if (field_z !== e.fz) begin
            $error("field_z expected %0d actual %0d", e.fz, field_z);
            errors++;
          end
          if (saturated !== e.sat) begin
            $error("saturated expected %0d actual %0d", e.sat, saturated);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst <= 1;
    cfg_we <= 0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_valid <= 0;
    {disp_x, disp_y, disp_z} <= '0;
    {spin_x, spin_y, spin_z} <= '0;
    neighbour_moment <= '0;
    centre_moment <= '0;
    is_self <= 0;
    last_neighbour <= 0;
    scale_r = 65536;
    cutoff_r = 0;
    tol_r = 0;
    acc_x = 0;
    acc_y = 0;
    acc_z = 0;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_random(0, 0, 65536, 64'hFFFF_FFFF_FFFF, 64'($urandom & 24'hFF_FFFF), 400);
    test_random(56, 0, 64'($urandom & 24'hFF_FFFF), 64'd1 << 30, 0, 400);
    test_random(0, 56, 24'hFF_FFFF, 64'hFFFF_FFFF_FFFF, 24'hFF_FFFF, 400);
    test_random(27, 27, 64'($urandom_range(1 << 18)), 64'd1 << 36,
                64'($urandom & 24'hFF_FFFF), 400);
    test_backpressure();
    wait_idle();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
